### src/orrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orrt_pkg
// Shared constants, codes and word types for the owner range region table.
// ----------------------------------------------------------------------------
package orrt_pkg;

  localparam int ENTRIES   = 128;
  localparam int PAGE_BITS = 12;
  localparam int PAGE_W    = 32 - PAGE_BITS;
  localparam int WRITE_BIT = 1;  // prot bit that grants write permission

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_LOOKUP     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ARGS = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_MATCH = 2'd3
  } status_t;

  // request held stable and broadcast to every cell during a scan
  typedef struct packed {
    opcode_t            op;
    logic [31:0]        owner;
    logic [PAGE_W-1:0]  s_pg;
    logic [PAGE_W-1:0]  e_pg;
    logic [31:0]        handle;
    logic [31:0]        base;
    logic               wr;
    logic [PAGE_W-1:0]  f_pg;
  } req_t;

  // word handed from one cell to the next
  typedef struct packed {
    logic               tok;
    logic               done;
    logic               any;
    logic [31:0]        handle;
    logic [31:0]        base;
    logic [PAGE_W-1:0]  start_pg;
    logic               wr;
  } link_t;

endpackage

### src/orrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orrt_cell
// One table slot. Acts on the request when the scan token passes through it
// and hands the registered token word on to its neighbour in the next cycle.
// ----------------------------------------------------------------------------
module orrt_cell
  import orrt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  req_t  req,
  input  link_t link_in,
  output link_t link_out
);

  logic              valid_r, valid_nxt;
  logic [31:0]       owner_r;
  logic [PAGE_W-1:0] start_r;
  logic [PAGE_W-1:0] end_r;
  logic [31:0]       handle_r;
  logic [31:0]       base_r;
  logic              wr_r;
  logic              load;
  link_t             link_r, link_nxt;
  logic              own_m;
  logic              act;

  assign own_m = valid_r && (owner_r == req.owner);
  assign act   = link_in.tok && !link_in.done;

  always_comb begin
    valid_nxt = valid_r;
    load      = 1'b0;
    link_nxt  = link_in;
    case (req.op)
      OP_REGISTER: begin
        if (act && !valid_r) begin
          load          = 1'b1;
          valid_nxt     = 1'b1;
          link_nxt.done = 1'b1;
        end
      end
      OP_UNREGISTER: begin
        if (act && own_m && start_r == req.s_pg && end_r == req.e_pg) begin
          valid_nxt     = 1'b0;
          link_nxt.done = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (link_in.tok && own_m) begin
          valid_nxt    = 1'b0;
          link_nxt.any = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (act && own_m && req.f_pg >= start_r && req.f_pg < end_r) begin
          link_nxt.done     = 1'b1;
          link_nxt.handle   = handle_r;
          link_nxt.base     = base_r;
          link_nxt.start_pg = start_r;
          link_nxt.wr       = wr_r;
        end
      end
      default: begin
        link_nxt = link_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      link_r.tok <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      link_r.tok <= link_nxt.tok;
    end
    link_r.done     <= link_nxt.done;
    link_r.any      <= link_nxt.any;
    link_r.handle   <= link_nxt.handle;
    link_r.base     <= link_nxt.base;
    link_r.start_pg <= link_nxt.start_pg;
    link_r.wr       <= link_nxt.wr;
    if (load) begin
      owner_r  <= req.owner;
      start_r  <= req.s_pg;
      end_r    <= req.e_pg;
      handle_r <= req.handle;
      base_r   <= req.base;
      wr_r     <= req.wr;
    end
  end

  assign link_out = link_r;

endmodule

### src/owner_range_region_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owner_range_region_table
// Owner-tagged address range table: register, unregister, clear and lookup.
// ----------------------------------------------------------------------------
// Operations run one at a time. A request whose arguments are rejected up
// front (bad bounds, negative handle, owner zero, unaligned unregister)
// answers in the cycle after acceptance. Any other request sends a token
// down the row of ENTRIES slot cells, one cell per cycle; the result is
// registered when the token leaves the last cell, and the next request is
// taken in the cycle after the result has been taken.
// The slot valid bits clear at reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module owner_range_region_table
  import orrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [31:0]        in_owner,
  input  logic [31:0]        in_start_addr,
  input  logic [31:0]        in_end_addr,
  input  logic signed [31:0] in_handle,
  input  logic [31:0]        in_file_offset,
  input  logic [31:0]        in_prot,
  input  logic [31:0]        in_fault_addr,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_hit,
  output logic [31:0]        out_page_addr,
  output logic signed [31:0] out_hit_handle,
  output logic [31:0]        out_page_file_offset,
  output logic               out_writable
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

  localparam logic [PAGE_BITS-1:0] LOW_ZERO = '0;

  state_t            state_r;
  req_t              req_r;
  logic              launch_r;
  link_t             links [ENTRIES+1];
  logic [ENTRIES-1:0] tok_vec;
  status_t           status_r;
  logic              hit_r;
  logic [31:0]       page_addr_r;
  logic [31:0]       handle_r;
  logic [31:0]       pfo_r;
  logic              wr_r;

  logic              in_acc;
  logic              s_low, e_low;
  logic              bad;
  status_t           bad_status;
  link_t             tail;
  logic [31:0]       pa;
  logic [31:0]       fo;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign s_low = (in_start_addr[PAGE_BITS-1:0] != LOW_ZERO);
  assign e_low = (in_end_addr[PAGE_BITS-1:0] != LOW_ZERO);

  // early answers that need no scan
  always_comb begin
    bad        = 1'b0;
    bad_status = ST_BAD_ARGS;
    case (opcode_t'(in_opcode))
      OP_REGISTER: begin
        bad = (in_end_addr <= in_start_addr) || in_handle[31] ||
              (in_owner == 32'd0) || s_low || e_low;
      end
      OP_UNREGISTER: begin
        if (in_owner == 32'd0) begin
          bad = 1'b1;
        end else if (s_low || e_low) begin
          bad        = 1'b1;
          bad_status = ST_NO_MATCH;
        end
      end
      OP_CLEAR: begin
        bad = 1'b0;
      end
      OP_LOOKUP: begin
        bad = (in_owner == 32'd0);
      end
      default: begin
        bad = 1'b0;
      end
    endcase
  end

  // token word entering the first cell
  always_comb begin
    links[0]     = '0;
    links[0].tok = launch_r;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    orrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .req      (req_r),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
    assign tok_vec[g] = links[g+1].tok;
  end

  assign tail = links[ENTRIES];
  assign pa   = {req_r.f_pg, LOW_ZERO};
  assign fo   = tail.base + (pa - {tail.start_pg, LOW_ZERO});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      launch_r <= 1'b0;
    end else begin
      launch_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (bad) begin
              state_r <= S_OUT;
            end else begin
              state_r  <= S_SCAN;
              launch_r <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (tail.tok) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end

    if (in_acc) begin
      req_r.op     <= opcode_t'(in_opcode);
      req_r.owner  <= in_owner;
      req_r.s_pg   <= in_start_addr[31:PAGE_BITS];
      req_r.e_pg   <= in_end_addr[31:PAGE_BITS];
      req_r.handle <= in_handle;
      req_r.base   <= in_file_offset;
      req_r.wr     <= in_prot[WRITE_BIT];
      req_r.f_pg   <= in_fault_addr[31:PAGE_BITS];
      status_r     <= bad_status;
      hit_r        <= 1'b0;
      page_addr_r  <= '0;
      handle_r     <= '0;
      pfo_r        <= '0;
      wr_r         <= 1'b0;
    end else if (state_r == S_SCAN && tail.tok) begin
      case (req_r.op)
        OP_REGISTER: begin
          status_r <= tail.done ? ST_OK : ST_FULL;
          hit_r    <= tail.done;
        end
        OP_UNREGISTER: begin
          status_r <= tail.done ? ST_OK : ST_NO_MATCH;
          hit_r    <= tail.done;
        end
        OP_CLEAR: begin
          status_r <= ST_OK;
          hit_r    <= tail.any;
        end
        OP_LOOKUP: begin
          status_r <= tail.done ? ST_OK : ST_NO_MATCH;
          hit_r    <= tail.done;
          if (tail.done) begin
            page_addr_r <= pa;
            handle_r    <= tail.handle;
            pfo_r       <= fo;
            wr_r        <= tail.wr;
          end
        end
        default: begin
          status_r <= ST_NO_MATCH;
        end
      endcase
    end
  end

  assign out_valid            = (state_r == S_OUT);
  assign out_status           = status_r;
  assign out_hit              = hit_r;
  assign out_page_addr        = page_addr_r;
  assign out_hit_handle       = handle_r;
  assign out_page_file_offset = pfo_r;
  assign out_writable         = wr_r;

  // only one scan token is ever in the row
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one scan token in the cell row");

  // the token leaves the row only while a scan is running
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.tok |-> (state_r == S_SCAN))
    else $error("scan token left the row outside a scan");

  // a launched token belongs to a scan
  a_launch_scan: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r |-> (state_r == S_SCAN))
    else $error("token launched outside a scan");

  // a hit never reports a non-ok status
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_status == ST_OK))
    else $error("hit reported with error status");

endmodule
